// File: design/hrcd_pkg.sv
// hrcd_pkg: shared types and byte constants for the chunked response decoder
// no dependencies; used by hrcd_head, hrcd_chunk and the top level by scoped names
package hrcd_pkg;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam int STATUS_W = 11;

    // commands to the header parser for one byte
    typedef struct packed {
        logic clear;
        logic step;
    } head_cmd_t;

    // header parser status toward the phase control
    typedef struct packed {
        logic                boundary_hit;
        logic                chunked_seen;
        logic [STATUS_W-1:0] status_code;
    } head_stat_t;

    // commands to the chunk size and length unit for one byte
    typedef struct packed {
        logic clear;
        logic begin_line;
        logic size_byte;
        logic data_byte;
        logic skip_byte;
    } chunk_cmd_t;

    // chunk unit status toward the phase control
    typedef struct packed {
        logic size_line_done;
        logic size_zero;
        logic data_last;
        logic skip_end;
    } chunk_stat_t;

    // whitespace as the C library sees it: space, tab, lf, vt, ff, cr
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

// File: design/hrcd_head.sv
// hrcd_head: status line parser, header pattern search and header boundary detector
// depends on hrcd_pkg
module hrcd_head
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hrcd_pkg::head_cmd_t  cmd,
    input  logic [7:0]           data,
    output hrcd_pkg::head_stat_t stat
);

    // status field states
    localparam logic [2:0] SF_WAIT  = 3'd0;
    localparam logic [2:0] SF_LEAD  = 3'd1;
    localparam logic [2:0] SF_SIGN  = 3'd2;
    localparam logic [2:0] SF_DIGIT = 3'd3;
    localparam logic [2:0] SF_END   = 3'd4;

    localparam logic [4:0] PATTERN_LAST = 5'd25;

    // lower-case text of "transfer-encoding: chunked"
    function automatic logic [7:0] pattern_char(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = 8'h74;
            5'd1:    ch = 8'h72;
            5'd2:    ch = 8'h61;
            5'd3:    ch = 8'h6E;
            5'd4:    ch = 8'h73;
            5'd5:    ch = 8'h66;
            5'd6:    ch = 8'h65;
            5'd7:    ch = 8'h72;
            5'd8:    ch = 8'h2D;
            5'd9:    ch = 8'h65;
            5'd10:   ch = 8'h6E;
            5'd11:   ch = 8'h63;
            5'd12:   ch = 8'h6F;
            5'd13:   ch = 8'h64;
            5'd14:   ch = 8'h69;
            5'd15:   ch = 8'h6E;
            5'd16:   ch = 8'h67;
            5'd17:   ch = 8'h3A;
            5'd18:   ch = 8'h20;
            5'd19:   ch = 8'h63;
            5'd20:   ch = 8'h68;
            5'd21:   ch = 8'h75;
            5'd22:   ch = 8'h6E;
            5'd23:   ch = 8'h6B;
            5'd24:   ch = 8'h65;
            5'd25:   ch = 8'h64;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    logic       line_done_reg, line_done_next;
    logic       cr_reg, cr_next;
    logic [2:0] field_reg, field_next;
    logic [9:0] value_reg, value_next;
    logic       neg_reg, neg_next;
    logic [4:0] match_reg, match_next;
    logic       chunked_reg, chunked_next;
    logic [1:0] bound_reg, bound_next;

    logic [7:0]  lc;
    logic        is_digit;
    logic [13:0] prod;
    logic [9:0]  value_sat;

    // byte classification and saturating decimal accumulate
    always_comb
    begin
        lc        = ((data >= 8'h41) && (data <= 8'h5A)) ? (data + 8'd32) : data;
        is_digit  = (data >= 8'h30) && (data <= 8'h39);
        prod      = ({4'd0, value_reg} * 14'd10) + {10'd0, data[3:0]};
        value_sat = (prod > 14'd999) ? 10'd999 : prod[9:0];
    end

    // next state for one header byte
    always_comb
    begin
        line_done_next = line_done_reg;
        cr_next        = cr_reg;
        field_next     = field_reg;
        value_next     = value_reg;
        neg_next       = neg_reg;
        match_next     = match_reg;
        chunked_next   = chunked_reg;
        bound_next     = bound_reg;
        if (cmd.clear)
        begin
            line_done_next = 1'b0;
            cr_next        = 1'b0;
            field_next     = SF_WAIT;
            value_next     = 10'd0;
            neg_next       = 1'b0;
            match_next     = 5'd0;
            chunked_next   = 1'b0;
            bound_next     = 2'd0;
        end
        else if (cmd.step)
        begin
            // status line
            if (!line_done_reg)
            begin
                if (cr_reg && (data == hrcd_pkg::CHAR_LF))
                begin
                    line_done_next = 1'b1;
                end
                else
                begin
                    case (field_reg)
                        SF_WAIT:
                        begin
                            if (data == hrcd_pkg::CHAR_SPACE)
                            begin
                                field_next = SF_LEAD;
                            end
                        end
                        SF_LEAD:
                        begin
                            if (data == hrcd_pkg::CHAR_SPACE)
                            begin
                                field_next = SF_END;
                            end
                            else if (hrcd_pkg::is_ws(data))
                            begin
                                field_next = SF_LEAD;
                            end
                            else if ((data == hrcd_pkg::CHAR_PLUS) ||
                                     (data == hrcd_pkg::CHAR_MINUS))
                            begin
                                neg_next   = (data == hrcd_pkg::CHAR_MINUS);
                                field_next = SF_SIGN;
                            end
                            else if (is_digit)
                            begin
                                value_next = value_sat;
                                field_next = SF_DIGIT;
                            end
                            else
                            begin
                                field_next = SF_END;
                            end
                        end
                        SF_SIGN, SF_DIGIT:
                        begin
                            if (is_digit)
                            begin
                                value_next = value_sat;
                                field_next = SF_DIGIT;
                            end
                            else
                            begin
                                field_next = SF_END;
                            end
                        end
                        default:
                        begin
                            field_next = field_reg;
                        end
                    endcase
                end
            end

            // case-insensitive pattern search
            if (!chunked_reg)
            begin
                if (lc == pattern_char(match_reg))
                begin
                    if (match_reg == PATTERN_LAST)
                    begin
                        chunked_next = 1'b1;
                        match_next   = 5'd0;
                    end
                    else
                    begin
                        match_next = match_reg + 5'd1;
                    end
                end
                else
                begin
                    match_next = (lc == pattern_char(5'd0)) ? 5'd1 : 5'd0;
                end
            end

            cr_next = (data == hrcd_pkg::CHAR_CR);

            // crlfcrlf boundary
            if ((bound_reg == 2'd3) && (data == hrcd_pkg::CHAR_LF))
            begin
                bound_next = 2'd0;
            end
            else if (data == hrcd_pkg::CHAR_CR)
            begin
                bound_next = (bound_reg == 2'd2) ? 2'd3 : 2'd1;
            end
            else if ((data == hrcd_pkg::CHAR_LF) && (bound_reg == 2'd1))
            begin
                bound_next = 2'd2;
            end
            else
            begin
                bound_next = 2'd0;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_done_reg <= 1'b0;
            cr_reg        <= 1'b0;
            field_reg     <= SF_WAIT;
            value_reg     <= 10'd0;
            neg_reg       <= 1'b0;
            match_reg     <= 5'd0;
            chunked_reg   <= 1'b0;
            bound_reg     <= 2'd0;
        end
        else
        begin
            line_done_reg <= line_done_next;
            cr_reg        <= cr_next;
            field_reg     <= field_next;
            value_reg     <= value_next;
            neg_reg       <= neg_next;
            match_reg     <= match_next;
            chunked_reg   <= chunked_next;
            bound_reg     <= bound_next;
        end
    end

    // status toward phase control and summary
    always_comb
    begin
        stat.boundary_hit = (bound_reg == 2'd3) && (data == hrcd_pkg::CHAR_LF);
        stat.chunked_seen = chunked_reg;
        if (!line_done_reg)
        begin
            stat.status_code = {hrcd_pkg::STATUS_W{1'b1}};
        end
        else if (field_reg == SF_WAIT)
        begin
            stat.status_code = '0;
        end
        else if (neg_reg)
        begin
            stat.status_code = 11'd0 - {1'b0, value_reg};
        end
        else
        begin
            stat.status_code = {1'b0, value_reg};
        end
    end

endmodule

// File: design/hrcd_chunk.sv
// hrcd_chunk: hex chunk size line parser, chunk byte counter and trailer skip
// depends on hrcd_pkg
module hrcd_chunk
#(
    parameter int CHUNK_SIZE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hrcd_pkg::chunk_cmd_t  cmd,
    input  logic [7:0]            data,
    output hrcd_pkg::chunk_stat_t stat
);

    // size line parse states
    localparam logic [2:0] HX_LEAD   = 3'd0;
    localparam logic [2:0] HX_SIGN   = 3'd1;
    localparam logic [2:0] HX_ZERO   = 3'd2;
    localparam logic [2:0] HX_PREFIX = 3'd3;
    localparam logic [2:0] HX_DIGIT  = 3'd4;
    localparam logic [2:0] HX_END    = 3'd5;

    localparam int W = CHUNK_SIZE_BITS;

    logic [2:0]   hex_reg, hex_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [1:0]   skip_reg, skip_next;
    logic         neg_reg, neg_next;
    logic         ovf_reg, ovf_next;
    logic         cr_reg, cr_next;

    logic         hex_ok;
    logic [3:0]   hex_val;
    logic [W-1:0] size_val;
    logic [1:0]   skip_dec;

    // hex digit decode
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = data[3:0];
        if ((data >= 8'h30) && (data <= 8'h39))
        begin
            hex_val = data[3:0];
        end
        else if (((data >= 8'h61) && (data <= 8'h66)) || ((data >= 8'h41) && (data <= 8'h46)))
        begin
            hex_val = data[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    // final size of the line and trailer countdown
    always_comb
    begin
        if (ovf_reg)
        begin
            size_val = '1;
        end
        else if (neg_reg)
        begin
            size_val = '0 - rem_reg;
        end
        else
        begin
            size_val = rem_reg;
        end
        skip_dec = (skip_reg != 2'd0) ? (skip_reg - 2'd1) : 2'd0;
    end

    // next state for one byte
    always_comb
    begin
        hex_next  = hex_reg;
        rem_next  = rem_reg;
        skip_next = skip_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        cr_next   = cr_reg;
        if (cmd.clear)
        begin
            hex_next  = HX_LEAD;
            rem_next  = '0;
            skip_next = 2'd0;
            neg_next  = 1'b0;
            ovf_next  = 1'b0;
            cr_next   = 1'b0;
        end
        else
        begin
            // size line byte
            if (cmd.size_byte)
            begin
                if (stat.size_line_done)
                begin
                    rem_next = size_val;
                    hex_next = HX_LEAD;
                    neg_next = 1'b0;
                    ovf_next = 1'b0;
                    cr_next  = 1'b0;
                end
                else
                begin
                    cr_next = (data == hrcd_pkg::CHAR_CR);
                    case (hex_reg)
                        HX_LEAD, HX_SIGN, HX_ZERO, HX_PREFIX, HX_DIGIT:
                        begin
                            if ((hex_reg == HX_LEAD) && hrcd_pkg::is_ws(data))
                            begin
                                hex_next = HX_LEAD;
                            end
                            else if ((hex_reg == HX_LEAD) &&
                                     ((data == hrcd_pkg::CHAR_PLUS) ||
                                      (data == hrcd_pkg::CHAR_MINUS)))
                            begin
                                neg_next = (data == hrcd_pkg::CHAR_MINUS);
                                hex_next = HX_SIGN;
                            end
                            else if (((hex_reg == HX_LEAD) || (hex_reg == HX_SIGN)) &&
                                     (data == hrcd_pkg::CHAR_ZERO))
                            begin
                                hex_next = HX_ZERO;
                            end
                            else if ((hex_reg == HX_ZERO) &&
                                     ((data == 8'h78) || (data == 8'h58)))
                            begin
                                hex_next = HX_PREFIX;
                            end
                            else if (hex_ok)
                            begin
                                // shift in one digit unless the size already saturated
                                if (!ovf_reg)
                                begin
                                    if (|rem_reg[W-1:W-4])
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                    else
                                    begin
                                        rem_next = {rem_reg[W-5:0], hex_val};
                                    end
                                end
                                hex_next = HX_DIGIT;
                            end
                            else
                            begin
                                hex_next = HX_END;
                            end
                        end
                        default:
                        begin
                            hex_next = hex_reg;
                        end
                    endcase
                end
            end

            // chunk data byte
            if (cmd.data_byte)
            begin
                rem_next = rem_reg - {{(W-1){1'b0}}, 1'b1};
                if (stat.data_last)
                begin
                    skip_next = 2'd2;
                end
            end

            // trailer byte
            if (cmd.skip_byte)
            begin
                skip_next = skip_dec;
            end

            // start of a new size line
            if (cmd.begin_line)
            begin
                hex_next = HX_LEAD;
                rem_next = '0;
                neg_next = 1'b0;
                ovf_next = 1'b0;
                cr_next  = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_reg  <= HX_LEAD;
            rem_reg  <= '0;
            skip_reg <= 2'd0;
            neg_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
            cr_reg   <= 1'b0;
        end
        else
        begin
            hex_reg  <= hex_next;
            rem_reg  <= rem_next;
            skip_reg <= skip_next;
            neg_reg  <= neg_next;
            ovf_reg  <= ovf_next;
            cr_reg   <= cr_next;
        end
    end

    // status toward phase control
    always_comb
    begin
        stat.size_line_done = cr_reg && (data == hrcd_pkg::CHAR_LF);
        stat.size_zero      = !ovf_reg && (rem_reg == '0);
        stat.data_last      = (rem_reg == {{(W-1){1'b0}}, 1'b1});
        stat.skip_end       = (skip_dec == 2'd0);
    end

endmodule

// File: design/http_response_chunked_decoder_core.sv
// http_response_chunked_decoder_core: top level, input register, phase control, result register
// depends on hrcd_pkg, hrcd_head and hrcd_chunk
//
//  channel | dir | tdata                      | tuser         | tlast
//  s_*     | in  | [7:0] data_byte            | [0] operation | -
//  m_*     | out | body_byte, status_code,    | -             | result_kind
//          |     | is_chunked, headers_compl, |               |
//          |     | chunk_truncated            |               |
//
// one transfer per cycle in each direction while the output is not stalled: an accepted item is
// decoded from the input register and its result, if any, is written to the output register
// the per-byte phase update (header parser, hex size accumulator, chunk counter) sets the rate
// rst_n clears all parser state; an end-of-response item also returns the parser to reset
// an item waits in the input register while the output register holds a result not yet taken
module http_response_chunked_decoder_core
#(
    parameter int CHUNK_SIZE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] body_byte, [18:8] status_code, [19] is_chunked,
                                   // [20] headers_complete, [21] chunk_truncated, [23:22] zero
    output logic        m_tlast    // result_kind
);

    // decode phases
    localparam logic [2:0] PH_HEAD  = 3'd0;
    localparam logic [2:0] PH_PLAIN = 3'd1;
    localparam logic [2:0] PH_SIZE  = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    logic [2:0] phase_reg, phase_next;

    logic                          out_valid_reg;
    logic                          out_kind_reg, out_kind_next;
    logic [7:0]                    out_byte_reg, out_byte_next;
    logic [hrcd_pkg::STATUS_W-1:0] out_code_reg, out_code_next;
    logic                          out_chunked_reg, out_chunked_next;
    logic                          out_hdr_reg, out_hdr_next;
    logic                          out_trunc_reg, out_trunc_next;

    logic advance;
    logic produce;

    hrcd_pkg::head_cmd_t   head_cmd;
    hrcd_pkg::head_stat_t  head_stat;
    hrcd_pkg::chunk_cmd_t  chunk_cmd;
    hrcd_pkg::chunk_stat_t chunk_stat;

    // handshake: the held item moves on when the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    hrcd_head u_head
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (head_cmd),
        .data  (in_byte_reg),
        .stat  (head_stat)
    );

    hrcd_chunk
    #(
        .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
    )
    u_chunk
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (chunk_cmd),
        .data  (in_byte_reg),
        .stat  (chunk_stat)
    );

    // phase control and result selection
    always_comb
    begin
        phase_next       = phase_reg;
        produce          = 1'b0;
        head_cmd         = '0;
        chunk_cmd        = '0;
        out_kind_next    = 1'b0;
        out_byte_next    = 8'd0;
        out_code_next    = '0;
        out_chunked_next = 1'b0;
        out_hdr_next     = 1'b0;
        out_trunc_next   = 1'b0;
        if (advance)
        begin
            if (in_op_reg)
            begin
                // end of response: summary, then back to reset state
                produce          = 1'b1;
                out_kind_next    = 1'b1;
                out_code_next    = head_stat.status_code;
                out_hdr_next     = (phase_reg != PH_HEAD);
                out_chunked_next = (phase_reg != PH_HEAD) && head_stat.chunked_seen;
                out_trunc_next   = (phase_reg == PH_DATA);
                head_cmd.clear   = 1'b1;
                chunk_cmd.clear  = 1'b1;
                phase_next       = PH_HEAD;
            end
            else
            begin
                case (phase_reg)
                    PH_HEAD:
                    begin
                        head_cmd.step = 1'b1;
                        if (head_stat.boundary_hit)
                        begin
                            if (head_stat.chunked_seen)
                            begin
                                chunk_cmd.begin_line = 1'b1;
                                phase_next           = PH_SIZE;
                            end
                            else
                            begin
                                phase_next = PH_PLAIN;
                            end
                        end
                    end
                    PH_PLAIN:
                    begin
                        produce       = 1'b1;
                        out_byte_next = in_byte_reg;
                    end
                    PH_SIZE:
                    begin
                        chunk_cmd.size_byte = 1'b1;
                        if (chunk_stat.size_line_done)
                        begin
                            phase_next = chunk_stat.size_zero ? PH_DONE : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        produce             = 1'b1;
                        out_byte_next       = in_byte_reg;
                        chunk_cmd.data_byte = 1'b1;
                        if (chunk_stat.data_last)
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        chunk_cmd.skip_byte = 1'b1;
                        if (chunk_stat.skip_end)
                        begin
                            chunk_cmd.begin_line = 1'b1;
                            phase_next           = PH_SIZE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_kind_reg    <= out_kind_next;
            out_byte_reg    <= out_byte_next;
            out_code_reg    <= out_code_next;
            out_chunked_reg <= out_chunked_next;
            out_hdr_reg     <= out_hdr_next;
            out_trunc_reg   <= out_trunc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_kind_reg;
    assign m_tdata  = {2'b00, out_trunc_reg, out_hdr_reg, out_chunked_reg,
                       out_code_reg, out_byte_reg};

endmodule
